// File: rtl/fecr_pkg.sv
// ----------------------------------------------------------------------------
// fecr_pkg: shared types and constants for the e-compass rotation matrix unit
// Shared-unit operation codes, register indexes and the sample width.
// ----------------------------------------------------------------------------
package fecr_pkg;

  localparam int ONE_Q14 = 16384;

  // input sample width; the datapath operand widths are sized for this value
  localparam int SAMPLE_BITS = 16;

  localparam logic [1:0] REG_ALPHA    = 2'd0;
  localparam logic [1:0] REG_FREEFALL = 2'd1;
  localparam logic [1:0] REG_FIELD    = 2'd2;

  // operation codes of the shared multiply/accumulate unit
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,  // acc = a*b
    MAC_ADD  = 2'd1,  // acc += a*b
    MAC_SUB  = 2'd2   // acc -= a*b
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_ctrl_t;

endpackage

// File: rtl/fecr_mac.sv
// ----------------------------------------------------------------------------
// fecr_mac: shared multiply-accumulate unit
// One signed 34x34 product into a 72-bit accumulator per enabled cycle.
// ----------------------------------------------------------------------------
module fecr_mac import fecr_pkg::*; (
  input  logic                clk,
  input  mac_ctrl_t           ctrl,
  input  logic signed [33:0]  a,
  input  logic signed [33:0]  b,
  output logic signed [71:0]  acc
);

  logic signed [67:0] prod;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // product is registered; accumulate in the cycle after
  mac_ctrl_t ctrl_d;
  always_ff @(posedge clk) begin
    ctrl_d <= ctrl;
    if (ctrl_d.en) begin
      case (ctrl_d.op)
        MAC_LOAD: acc <= 72'(prod);
        MAC_ADD:  acc <= acc + 72'(prod);
        MAC_SUB:  acc <= acc - 72'(prod);
        default:  acc <= acc;
      endcase
    end
  end

endmodule

// File: rtl/fecr_div.sv
// ----------------------------------------------------------------------------
// fecr_div: shared radix-2 unsigned divider and square root
// Restoring division or digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module fecr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        sqrt_mode,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [63:0] res
);

  logic [63:0]  rem;
  logic [63:0]  val;
  logic [63:0]  bitv;
  logic [63:0]  dv;
  logic         mode;
  logic [6:0]   cnt;
  logic [127:0] shl;

  always_comb begin
    shl = {64'd0, rem} << 1;
    shl[0] = val[63];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      mode <= sqrt_mode;
      cnt  <= sqrt_mode ? 7'd32 : 7'd64;
      rem  <= sqrt_mode ? num : 64'd0;
      val  <= num;
      dv   <= den;
      res  <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
      if (mode) begin
        if (rem >= res + bitv) begin
          rem <= rem - (res + bitv);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        val <= val << 1;
        if (shl >= {64'd0, dv}) begin
          rem <= 64'(shl - {64'd0, dv});
          res <= {res[62:0], 1'b1};
        end else begin
          rem <= shl[63:0];
          res <= {res[62:0], 1'b0};
        end
      end
    end
  end

endmodule

// File: rtl/filtered_ecompass_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// filtered_ecompass_rotation_matrix_unit: low-pass filtered tilt-compensated
// e-compass rotation matrix
// ----------------------------------------------------------------------------
// Each accepted sample set runs through a small sequencer to a valid result
// (the quotients are skipped when the frame is degenerate). The sequencer
// drives one shared multiplier-accumulator for the filters, the east and north
// cross products and the squared norms, and one shared bit-serial divide/square
// root unit for the two norms and six rounded quotients, which take most of
// the time. in_stall stays high from acceptance until the result is taken.
// The result is held in an output register until out_stall drops.
module filtered_ecompass_rotation_matrix_unit import fecr_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [23:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  input  logic signed [SAMPLE_BITS-1:0] mag_x,
  input  logic signed [SAMPLE_BITS-1:0] mag_y,
  input  logic signed [SAMPLE_BITS-1:0] mag_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            east_x,
  output logic signed [15:0]            east_y,
  output logic signed [15:0]            east_z,
  output logic signed [15:0]            north_x,
  output logic signed [15:0]            north_y,
  output logic signed [15:0]            north_z,
  output logic signed [15:0]            up_x,
  output logic signed [15:0]            up_y,
  output logic signed [15:0]            up_z,
  output logic                          degenerate
);

  localparam int SB = SAMPLE_BITS + 8;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FILT  = 10'b0000000010,
    S_CROSS = 10'b0000000100,
    S_SQ    = 10'b0000001000,
    S_ROOT  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_MCRS  = 10'b0001000000,
    S_MDIV  = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state;
  logic [15:0] alpha;
  logic [23:0] ff_thr, fld_thr;
  logic signed [SB-1:0] fa [3];
  logic signed [SB-1:0] fm [3];
  logic signed [SAMPLE_BITS-1:0] smp [6];
  logic signed [63:0] h [3];
  logic [63:0] sa, sh, na, nh;
  logic [5:0] shamt;
  logic signed [15:0] ua [3];
  logic signed [15:0] uh [3];
  logic signed [15:0] um [3];
  logic [3:0] idx;
  logic [2:0] ph;
  logic deg;

  // shared MAC
  mac_ctrl_t mctl;
  logic signed [33:0] ma, mb;
  logic signed [71:0] acc;
  fecr_mac u_mac (.clk(clk), .ctrl(mctl), .a(ma), .b(mb), .acc(acc));

  // shared divider / root
  logic dstart, dsqrt, dbusy;
  logic [63:0] dnum, dden, dres;
  fecr_div u_div (.clk(clk), .rst(rst), .start(dstart), .sqrt_mode(dsqrt),
                  .num(dnum), .den(dden), .busy(dbusy), .res(dres));

  assign cfg_ready = !rst && (state == S_IDLE);
  assign in_stall  = rst || (state != S_IDLE);

  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    if (v > 64'sd16384) return 16'sd16384;
    if (v < -64'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // per-step operand selection
  logic signed [63:0] fprev, fdiff;
  logic signed [71:0] fsum;
  logic signed [71:0] rnd;
  logic signed [63:0] fnew;
  logic signed [63:0] hsv, num_s;
  logic [63:0] maxh;

  always_comb begin
    fprev = idx < 4'd3 ? 64'(fa[idx[1:0]]) : 64'(fm[2'(idx - 4'd3)]);
    fdiff = 64'(smp[idx[2:0]]) * 64'sd256 - fprev;
    // round alpha*d/2^16 half away from zero
    rnd   = acc < 0 ? -((-acc + 72'sd32768) >>> 16) : ((acc + 72'sd32768) >>> 16);
    fsum  = 72'(fprev) + rnd;
    if (fsum > 72'((64'sd1 <<< (SB-1)) - 1)) fnew = (64'sd1 <<< (SB-1)) - 1;
    else if (fsum < -72'(64'sd1 <<< (SB-1))) fnew = -(64'sd1 <<< (SB-1));
    else fnew = 64'(fsum);
    maxh = mag(h[0]);
    if (mag(h[1]) > maxh) maxh = mag(h[1]);
    if (mag(h[2]) > maxh) maxh = mag(h[2]);
    hsv = h[idx[1:0]] < 0 ? -64'(mag(h[idx[1:0]]) >> shamt)
                          : 64'(mag(h[idx[1:0]]) >> shamt);
    num_s = idx < 4'd3 ? hsv * 64'sd16384 : 64'(fa[2'(idx - 4'd3)]) * 64'sd16384;
  end

  logic num_neg;

  always_ff @(posedge clk) begin
    mctl   <= '{en: 1'b0, op: MAC_LOAD};
    dstart <= 1'b0;
    if (rst) begin
      state   <= S_IDLE;
      out_valid <= 1'b0;
      alpha   <= 16'd7864;
      ff_thr  <= 24'd63072;
      fld_thr <= 24'd6554;
      for (int i = 0; i < 3; i++) begin
        fa[i] <= '0;
        fm[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_ALPHA:    alpha   <= cfg_data[15:0];
              REG_FREEFALL: ff_thr  <= cfg_data;
              REG_FIELD:    fld_thr <= cfg_data;
              default: ;
            endcase
          end
          if (in_valid) begin
            smp[0] <= accel_x; smp[1] <= accel_y; smp[2] <= accel_z;
            smp[3] <= mag_x;   smp[4] <= mag_y;   smp[5] <= mag_z;
            idx <= '0; ph <= '0;
            state <= S_FILT;
          end
        end
        // each axis: issue alpha*d, wait for the MAC result, update
        S_FILT: begin
          ph <= ph + 3'd1;
          if (ph == 3'd0) begin
            ma <= 34'(fdiff); mb <= 34'({1'b0, alpha});
            mctl <= '{en: 1'b1, op: MAC_LOAD};
          end else if (ph == 3'd3) begin
            ph <= '0;
            if (idx < 4'd3) fa[idx[1:0]] <= SB'(fnew);
            else fm[2'(idx - 4'd3)] <= SB'(fnew);
            idx <= idx + 4'd1;
            if (idx == 4'd5) begin idx <= '0; state <= S_CROSS; end
          end
        end
        // h[i] = e[j]*a[k] - e[k]*a[j]
        S_CROSS: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd0: begin
              ma <= 34'(fm[(idx == 0) ? 1 : (idx == 1) ? 2 : 0]);
              mb <= 34'(fa[(idx == 0) ? 2 : (idx == 1) ? 0 : 1]);
              mctl <= '{en: 1'b1, op: MAC_LOAD};
            end
            3'd1: begin
              ma <= 34'(fm[(idx == 0) ? 2 : (idx == 1) ? 0 : 1]);
              mb <= 34'(fa[(idx == 0) ? 1 : (idx == 1) ? 2 : 0]);
              mctl <= '{en: 1'b1, op: MAC_SUB};
            end
            3'd4: begin
              h[idx[1:0]] <= 64'(acc);
              ph <= '0;
              idx <= idx + 4'd1;
              if (idx == 4'd2) begin idx <= '0; state <= S_SQ; end
            end
            default: ;
          endcase
        end
        // sa = sum a^2, then sh = sum hs^2
        S_SQ: begin
          ph <= ph + 3'd1;
          if (ph == 3'd0) begin
            // smallest shift that brings every |h| below 2^30
            shamt <= '0;
            for (int s = 1; s <= 40; s++)
              if ((maxh >> (s - 1)) >= 64'h4000_0000) shamt <= 6'(s);
          end else if (ph <= 3'd3) begin
            ma <= 34'(fa[2'(ph - 3'd1)]); mb <= 34'(fa[2'(ph - 3'd1)]);
            mctl <= '{en: 1'b1, op: (ph == 3'd1) ? MAC_LOAD : MAC_ADD};
          end else if (ph == 3'd6) begin
            sa <= 64'(acc);
            idx <= '0;
          end else if (ph == 3'd7) begin
            ph <= 3'd7;
            idx <= idx + 4'd1;
            if (idx < 4'd3) begin
              ma <= 34'(mag(h[idx[1:0]]) >> shamt);
              mb <= 34'(mag(h[idx[1:0]]) >> shamt);
              mctl <= '{en: 1'b1, op: (idx == 4'd0) ? MAC_LOAD : MAC_ADD};
            end else if (idx == 4'd5) begin
              sh <= 64'(acc);
              idx <= '0; ph <= '0;
              state <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          if (ph == 3'd0) begin
            dstart <= 1'b1; dsqrt <= 1'b1; dnum <= sa; ph <= 3'd1;
          end else if (ph == 3'd1) begin
            ph <= 3'd2;
          end else if (ph == 3'd2 && !dbusy) begin
            na <= dres;
            dstart <= 1'b1; dsqrt <= 1'b1; dnum <= sh; ph <= 3'd3;
          end else if (ph == 3'd3) begin
            ph <= 3'd4;
          end else if (ph == 3'd4 && !dbusy) begin
            nh <= dres;
            deg <= (sa < {24'd0, ff_thr, 16'd0})
                || (shamt <= 6'd24 && (dres << shamt) < {24'd0, fld_thr, 16'd0})
                || dres == 64'd0 || na == 64'd0;
            ph <= '0; idx <= '0;
            state <= S_DIV;
          end
        end
        // (2|n| + d) / (2d) for uh then ua
        S_DIV: begin
          if (deg) begin
            state <= S_OUT;
          end else if (ph == 3'd0) begin
            num_neg <= num_s < 0;
            dnum <= 2 * mag(num_s) + ((idx < 4'd3) ? nh : na);
            dden <= 2 * ((idx < 4'd3) ? nh : na);
            dstart <= 1'b1; dsqrt <= 1'b0; ph <= 3'd1;
          end else if (ph == 3'd1) begin
            ph <= 3'd2;
          end else if (!dbusy) begin
            if (idx < 4'd3) uh[idx[1:0]] <= sat14(num_neg ? -64'(dres) : 64'(dres));
            else ua[2'(idx - 4'd3)] <= sat14(num_neg ? -64'(dres) : 64'(dres));
            ph <= '0;
            idx <= idx + 4'd1;
            if (idx == 4'd5) begin idx <= '0; state <= S_MCRS; end
          end
        end
        S_MCRS: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd0: begin
              ma <= 34'(ua[(idx == 0) ? 1 : (idx == 1) ? 2 : 0]);
              mb <= 34'(uh[(idx == 0) ? 2 : (idx == 1) ? 0 : 1]);
              mctl <= '{en: 1'b1, op: MAC_LOAD};
            end
            3'd1: begin
              ma <= 34'(ua[(idx == 0) ? 2 : (idx == 1) ? 0 : 1]);
              mb <= 34'(uh[(idx == 0) ? 1 : (idx == 1) ? 2 : 0]);
              mctl <= '{en: 1'b1, op: MAC_SUB};
            end
            3'd4: begin
              // divide by 2^14, ties away from zero
              um[idx[1:0]] <= sat14(acc < 0 ? -64'((-acc + 72'sd8192) >>> 14)
                                            : 64'((acc + 72'sd8192) >>> 14));
              ph <= '0;
              idx <= idx + 4'd1;
              if (idx == 4'd2) state <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!out_valid) begin
            if (deg) begin
              {east_x, east_y, east_z} <= {16'sd16384, 16'sd0, 16'sd0};
              {north_x, north_y, north_z} <= {16'sd0, 16'sd16384, 16'sd0};
              {up_x, up_y, up_z} <= {16'sd0, 16'sd0, 16'sd16384};
            end else begin
              {east_x, east_y, east_z} <= {uh[0], uh[1], uh[2]};
              {north_x, north_y, north_z} <= {um[0], um[1], um[2]};
              {up_x, up_y, up_z} <= {ua[0], ua[1], ua[2]};
            end
            degenerate <= deg;
            out_valid <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // MDIV state is reserved; sequencer never enters it
  assert property (@(posedge clk) disable iff (rst) state != S_MDIV)
    else $error("unexpected state");
  assert property (@(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> east_x == 16'sd16384 && up_z == 16'sd16384)
    else $error("degenerate frame is not identity");
  assert property (@(posedge clk) disable iff (rst) dbusy |-> in_stall)
    else $error("divider busy while idle");

endmodule
